[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/pica_pkg.sv]
// ---------------------------------------------------------------------------
// pica_pkg
// widths, register indexes and control types of the pi controller
// ---------------------------------------------------------------------------
`default_nettype none

package pica_pkg;

  localparam int DATA_W  = 16;              // config, input and drive words
  localparam int IDX_W   = 8;               // config register index
  localparam int ERR_W   = DATA_W + 1;      // setpoint - measured, q9.8
  localparam int MA_W    = 33;              // multiplier operand a
  localparam int MB_W    = DATA_W + 1;      // multiplier operand b (unsigned, zero ext)
  localparam int PROD_W  = MA_W + MB_W;     // full signed product
  localparam int INTEG_W = 40;              // integral, q16.24
  localparam int SUM_W   = INTEG_W + 2;     // sums before saturation / compare
  localparam int FRAC_SH = 8;               // q.32 -> q.24 for the increment
  localparam int OUT_SH  = 16;              // q.24 -> q.8 for the drive

  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
  localparam logic [IDX_W-1:0] REG_OUT_LOW    = 8'd2;
  localparam logic [IDX_W-1:0] REG_OUT_HIGH   = 8'd3;

  localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 16'd2560;
  localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 16'd1311;
  localparam logic [DATA_W-1:0] OUT_LOW_RST    = 16'd0;
  localparam logic [DATA_W-1:0] OUT_HIGH_RST   = 16'd20480;

  typedef enum logic [1:0] {
    MSEL_KI = 2'd0,   // err * integ_gain
    MSEL_DT = 2'd1,   // previous product * time_step
    MSEL_KP = 2'd2    // err * prop_gain
  } mul_sel_t;

  typedef struct packed {
    logic     ld_en;    // capture input word
    logic     mul_en;   // load product register
    mul_sel_t mul_sel;
    logic     acc_en;   // form saturated trial integral
    logic     fin_en;   // finish: write result word, maybe update integral
  } ctl_t;

endpackage

`default_nettype wire

[rtl/pica_mul.sv]
// ---------------------------------------------------------------------------
// pica_mul
// shared signed multiplier with registered product
// ---------------------------------------------------------------------------
`default_nettype none

module pica_mul (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [pica_pkg::MA_W-1:0]  a,
  input  wire logic signed [pica_pkg::MB_W-1:0]  b,
  output logic signed [pica_pkg::PROD_W-1:0]     prod_r
);

  logic signed [pica_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = pica_pkg::PROD_W'(a) * pica_pkg::PROD_W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pica_ctrl.sv]
// ---------------------------------------------------------------------------
// pica_ctrl
// sequencer stepping one word through the shared multiplier
// ---------------------------------------------------------------------------
`default_nettype none

module pica_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         slot_free,   // result register empty or being taken
  output pica_pkg::ctl_t    ctl
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ctl.ld_en   = 1'b0;
    ctl.mul_en  = 1'b0;
    ctl.mul_sel = pica_pkg::MSEL_KI;
    ctl.acc_en  = 1'b0;
    ctl.fin_en  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.ld_en = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pica_pkg::MSEL_KI;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pica_pkg::MSEL_DT;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        // trial integral and proportional product in the same cycle
        ctl.acc_en  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pica_pkg::MSEL_KP;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          ctl.fin_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pi_controller_antiwindup.sv]
// ---------------------------------------------------------------------------
// pi_controller_antiwindup
// fixed-point pi controller with clamping (conditional integration) anti-windup
// ---------------------------------------------------------------------------
// Each input word (setpoint, measured, time_step) yields one result word
// (drive, clamped). An input word is taken only when the sequencer is idle,
// and its result is formed by three passes through one shared 33x17 signed
// multiplier, then a finishing step; the next word is taken only after that
// finishing step. The result sits in an output register, so a new word can
// be accepted while the previous result still waits; the finishing step
// waits if that register is still full. The integral is held when the
// output saturates against out_low / out_high; with crossed limits every
// word is clamped to out_low. Configuration writes are always ready;
// indexes beyond out_high are ignored.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pi_controller_antiwindup (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input words
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [pica_pkg::DATA_W-1:0]   in_setpoint,
  input  wire logic signed [pica_pkg::DATA_W-1:0]   in_measured,
  input  wire logic        [pica_pkg::DATA_W-1:0]   in_time_step,
  // result words
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [pica_pkg::DATA_W-1:0]        out_drive,
  output logic                                      out_clamped,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pica_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [pica_pkg::DATA_W-1:0]          cfg_data
);

  localparam int DW  = pica_pkg::DATA_W;
  localparam int SW  = pica_pkg::SUM_W;
  localparam int IW  = pica_pkg::INTEG_W;
  localparam int PW  = pica_pkg::PROD_W;
  localparam int MAW = pica_pkg::MA_W;
  localparam int EW  = pica_pkg::ERR_W;

  // ---- configuration registers ----
  logic        [DW-1:0] prop_gain_r;
  logic        [DW-1:0] integ_gain_r;
  logic signed [DW-1:0] out_low_r;
  logic signed [DW-1:0] out_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= pica_pkg::PROP_GAIN_RST;
      integ_gain_r <= pica_pkg::INTEG_GAIN_RST;
      out_low_r    <= pica_pkg::OUT_LOW_RST;
      out_high_r   <= pica_pkg::OUT_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pica_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        pica_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_data;
        pica_pkg::REG_OUT_LOW:    out_low_r    <= cfg_data;
        pica_pkg::REG_OUT_HIGH:   out_high_r   <= cfg_data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ---- sequencer ----
  pica_pkg::ctl_t ctl;
  logic           slot_free;

  assign slot_free = !out_valid || out_ready;

  pica_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .ctl       (ctl)
  );

  // ---- input capture: error is q9.8 and never saturates ----
  logic signed [EW-1:0] err_r;
  logic        [DW-1:0] dt_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_en) begin
      err_r <= EW'(in_setpoint) - EW'(in_measured);
      dt_r  <= in_time_step;
    end
  end

  // ---- shared multiplier and its operand select ----
  logic signed [MAW-1:0]               mul_a;
  logic signed [pica_pkg::MB_W-1:0]    mul_b;
  logic signed [PW-1:0]                prod_r;

  always_comb begin
    case (ctl.mul_sel)
      pica_pkg::MSEL_KI: begin
        mul_a = MAW'(err_r);
        mul_b = {1'b0, integ_gain_r};
      end
      pica_pkg::MSEL_DT: begin
        // ki * err fits in 33 bits signed
        mul_a = prod_r[MAW-1:0];
        mul_b = {1'b0, dt_r};
      end
      pica_pkg::MSEL_KP: begin
        mul_a = MAW'(err_r);
        mul_b = {1'b0, prop_gain_r};
      end
      default: begin
        mul_a = MAW'(err_r);
        mul_b = {1'b0, integ_gain_r};
      end
    endcase
  end

  pica_mul u_mul (
    .clk    (clk),
    .en     (ctl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // ---- trial integral: stored + floor(ki*err*dt / 2^8), saturated to 40 bits ----
  logic signed [IW-1:0] integ_r;
  logic signed [IW-1:0] trial_r;
  logic signed [SW-1:0] inc_w;
  logic signed [SW-1:0] trial_wide;
  logic signed [IW-1:0] trial_nxt;

  // arithmetic shift of the 50-bit product gives the floor
  assign inc_w      = SW'(prod_r >>> pica_pkg::FRAC_SH);
  assign trial_wide = SW'(integ_r) + inc_w;

  always_comb begin
    // upper bits not a sign extension means overflow past 40 bits
    if (trial_wide[SW-1:IW-1] == '0 || trial_wide[SW-1:IW-1] == '1) begin
      trial_nxt = trial_wide[IW-1:0];
    end else if (trial_wide[SW-1]) begin
      trial_nxt = {1'b1, {(IW-1){1'b0}}};
    end else begin
      trial_nxt = {1'b0, {(IW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      trial_r <= trial_nxt;
    end
  end

  // ---- unclamped sum kp*err*2^8 + trial, compared against the q16.24 limits ----
  logic signed [SW-1:0] sum_w;
  logic signed [SW-1:0] lo_wide;
  logic signed [SW-1:0] hi_wide;
  logic                 below_w;
  logic                 above_w;
  logic                 clamp_w;
  logic signed [DW-1:0] drive_w;

  // kp * err is signed, so sign-extend the 33-bit product
  assign sum_w   = (SW'($signed(prod_r[MAW-1:0])) <<< pica_pkg::FRAC_SH) + SW'(trial_r);
  assign lo_wide = SW'(out_low_r)  <<< pica_pkg::OUT_SH;
  assign hi_wide = SW'(out_high_r) <<< pica_pkg::OUT_SH;
  assign below_w = sum_w < lo_wide;
  assign above_w = sum_w > hi_wide;
  assign clamp_w = below_w || above_w;

  always_comb begin
    if (!clamp_w) begin
      drive_w = sum_w[pica_pkg::OUT_SH+DW-1:pica_pkg::OUT_SH];
    end else if (below_w || (out_low_r > out_high_r)) begin
      // low side wins, and crossed limits always give out_low
      drive_w = out_low_r;
    end else begin
      drive_w = out_high_r;
    end
  end

  // integral keeps the trial value only when the output stayed in range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (ctl.fin_en && !clamp_w) begin
      integ_r <= trial_r;
    end
  end

  // ---- result register ----
  logic                 out_valid_r;
  logic signed [DW-1:0] drive_r;
  logic                 clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_en) begin
      drive_r   <= drive_w;
      clamped_r <= clamp_w;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = drive_r;
  assign out_clamped = clamped_r;

  // ---- assertions ----
  // held integral when the output word was clamped
  `ASSERT_NEXT(a_hold_on_clamp, clk, rst_n, ctl.fin_en && clamp_w, $stable(integ_r))
  // an unclamped drive lies inside the limits
  `ASSERT_IMPL(a_drive_in_range, clk, rst_n, out_valid_r && !clamped_r, (drive_r >= out_low_r) && (drive_r <= out_high_r))
  // a clamped drive is one of the limits
  `ASSERT_IMPL(a_clamp_at_limit, clk, rst_n, out_valid_r && clamped_r, (drive_r == out_low_r) || (drive_r == out_high_r))
  // the sequencer is busy right after taking a word
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
